// ===== src/itoa_pkg.sv =====
// Widths, format codes and the digit-to-character function of the integer-to-ASCII block.
package itoa_pkg;

    // Word width and the number of digits kept per number
    localparam int VALUE_WIDTH = 32;
    localparam int MAX_DIGITS  = 10;

    // Derived widths
    localparam int TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int DIG_W   = MAX_DIGITS * 4;
    localparam int CNT_W   = $clog2(VALUE_WIDTH);
    localparam int IDX_W   = $clog2(MAX_DIGITS);

    // ASCII characters
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h61;

    // Format codes carried on tuser; the spare code reads as unsigned decimal
    typedef enum logic [1:0] {
        FMT_SDEC = 2'd0,
        FMT_UDEC = 2'd1,
        FMT_HEX  = 2'd2
    } t_fmt;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_FIND,
        ST_EMIT
    } t_state;

    // One digit (decimal or hex) to its lower-case ASCII character
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = 8'(CH_ZERO + {4'b0000, d});
        end else begin
            c = 8'(CH_A + {4'b0000, d} - 8'd10);
        end
        return c;
    endfunction

endpackage

// ===== src/integer_to_ascii_digits_top.sv =====
// Integer-to-ASCII converter: shift-and-adjust digit extraction and character emitter.
//
//  Channel   Direction  tdata (low bit up)           tuser / tlast
//  s_axis    in         value[VALUE_WIDTH-1:0], pad  tuser: format_kind[1:0]
//  m_axis    out        out_char[7:0]                tlast: last_char
//
// A number is accepted in idle, then passes one shift-and-adjust step per input bit and a step
// that finds the leading digit, and then the emit state sends one character at a time;
// a stalled output holds the emit state.
// The single shift-and-adjust unit over the digit register handles the input bits in turn.
// Reset (synchronous, active low) returns the sequencer to idle and empties the output.
// The output register holds a character until taken; a new number is accepted as
// soon as the last character of the previous one sits in that register.
module integer_to_ascii_digits_top
    import itoa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // value[VALUE_WIDTH-1:0], zero padding
    input  logic [1:0]         s_axis_tuser,   // format_kind[1:0]
    // Output stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // out_char[7:0]
    output logic               m_axis_tlast    // last_char
);

    t_state                 r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_work, n_work;
    logic [DIG_W-1:0]       r_digits, n_digits;
    logic                   r_ovf, n_ovf;
    logic                   r_hex, n_hex;
    logic                   r_sign, n_sign;
    logic [CNT_W-1:0]       r_bit_cnt, n_bit_cnt;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_out_char, n_out_char;
    logic                   r_out_last, n_out_last;

    logic                   in_xfer;
    logic                   out_free;
    logic [VALUE_WIDTH-1:0] in_value;
    t_fmt                   in_fmt;
    logic [DIG_W-1:0]       adj_digits;
    logic [IDX_W-1:0]       top_idx;
    logic [3:0]             cur_digit;

    assign in_value = s_axis_tdata[VALUE_WIDTH-1:0];
    assign in_fmt   = t_fmt'(s_axis_tuser);
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tlast  = r_out_last;

    // Add-3 correction in decimal mode on every digit of 5 or more before the decimal doubling
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (!r_hex && (r_digits[4*i +: 4] >= 4'd5)) begin
                adj_digits[4*i +: 4] = r_digits[4*i +: 4] + 4'd3;
            end else begin
                adj_digits[4*i +: 4] = r_digits[4*i +: 4];
            end
        end
    end

    // Leading digit position; digits lost off the top keep the full width
    always_comb begin
        top_idx = '0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (r_digits[4*i +: 4] != 4'd0) begin
                top_idx = IDX_W'(i);
            end
        end
        if (r_ovf) begin
            top_idx = IDX_W'(MAX_DIGITS - 1);
        end
    end

    assign cur_digit = r_digits[4*r_idx +: 4];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (r_bit_cnt == '0) begin
                    n_state = ST_FIND;
                end
            end
            ST_FIND: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free && !r_sign && (r_idx == '0)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and output register
    always_comb begin
        n_work      = r_work;
        n_digits    = r_digits;
        n_ovf       = r_ovf;
        n_hex       = r_hex;
        n_sign      = r_sign;
        n_bit_cnt   = r_bit_cnt;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_hex     = (in_fmt == FMT_HEX);
                    n_sign    = (in_fmt == FMT_SDEC) && in_value[VALUE_WIDTH-1];
                    n_work    = n_sign ? (~in_value + 1'b1) : in_value;
                    n_digits  = '0;
                    n_ovf     = 1'b0;
                    n_bit_cnt = CNT_W'(VALUE_WIDTH - 1);
                end
            end
            ST_SHIFT: begin
                // Next word bit enters the digit register from below
                n_digits  = {adj_digits[DIG_W-2:0], r_work[VALUE_WIDTH-1]};
                n_ovf     = r_ovf | adj_digits[DIG_W-1];
                n_work    = r_work << 1;
                n_bit_cnt = r_bit_cnt - 1'b1;
            end
            ST_FIND: begin
                n_idx = top_idx;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_sign) begin
                        n_out_char = CH_MINUS;
                        n_out_last = 1'b0;
                        n_sign     = 1'b0;
                    end else begin
                        n_out_char = digit_char(cur_digit);
                        n_out_last = (r_idx == '0);
                        if (r_idx != '0) begin
                            n_idx = r_idx - 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_work     <= n_work;
        r_digits   <= n_digits;
        r_ovf      <= n_ovf;
        r_hex      <= n_hex;
        r_sign     <= n_sign;
        r_bit_cnt  <= n_bit_cnt;
        r_idx      <= n_idx;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    // An accepted number starts the shift phase next cycle
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == ST_SHIFT))
        else $error("accepted number did not start conversion");

    // Shift phase always begins with the full bit count
    a_shift_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_SHIFT) |-> (r_bit_cnt == CNT_W'(VALUE_WIDTH - 1)))
        else $error("shift phase started with wrong bit count");

    // The digit pointer stays within the digit register while emitting
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_idx <= IDX_W'(MAX_DIGITS - 1)))
        else $error("digit pointer out of range");

    // A minus sign is never the final character of a number
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata != CH_MINUS))
        else $error("minus sign flagged as last character");

endmodule
